@@ rtl/core/frtd_pkg.sv @@
// Shared types, constants and rounding helpers for the table reciprocal divider.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package frtd_pkg;

    // Table geometry: one constant and one linear coefficient per interval.
    localparam int TABLE_DEPTH  = 16;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int SLOT_W       = 5;
    localparam int WORD_W       = 64;
    localparam int FP_W         = 32;
    localparam int FRAC_BITS    = 23;
    localparam int XS           = FRAC_BITS - IDX_W;
    localparam int EXP_BIAS     = 127;
    localparam int Y_SCALE_LOG2 = 24;

    // Coefficient fraction width registers.
    localparam int WIDTH_W   = 6;
    localparam int WIDTH_MIN = 1;
    localparam int WIDTH_MAX = 40;
    localparam int WIDTH_RST = 23;
    localparam int CFG_IDX_W = 1;

    // Datapath widths.
    localparam int COEF_W = WIDTH_MAX + 1;
    localparam int XL_W   = XS;
    localparam int PROD_W = COEF_W + XL_W;

    localparam logic [FP_W-1:0] CANON_NAN = 32'h7FC0_0000;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int PIPE_LATENCY = 11;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_RECIP  = 2'd1,
        OP_DIVIDE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONST_WIDTH  = 1'b0,
        CFG_LINEAR_WIDTH = 1'b1
    } t_cfg_index;

    typedef logic signed [10:0] t_exp;

    // Reciprocal handed from the table pipeline to the multiplier.
    typedef struct packed {
        logic            valid;
        logic            is_div;
        logic [FP_W-1:0] num;
        logic [FP_W-1:0] recip;
    } t_recip_res;

    // Leading zero count of a 64-bit word; 64 for zero.
    function automatic logic [6:0] clz64(logic [63:0] v);
        logic [6:0] c;
        c = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                c = 7'(63 - i);
            end
        end
        return c;
    endfunction

    // Leading zero count of a 48-bit word; 48 for zero.
    function automatic logic [5:0] clz48(logic [47:0] v);
        logic [5:0] c;
        c = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                c = 6'(47 - i);
            end
        end
        return c;
    endfunction

    // Packs a normalised significand (bit 47 set) with a biased exponent into
    // fp32, rounding to nearest even, with gradual underflow and overflow.
    function automatic logic [FP_W-1:0] round_pack(logic sgn, t_exp be, logic [47:0] n);
        logic [47:0]     m;
        logic            lost;
        logic [30:0]     base;
        logic            inc;
        logic [5:0]      sh;
        t_exp            shf;
        logic [FP_W-1:0] res;
        m    = n;
        lost = 1'b0;
        base = '0;
        sh   = '0;
        shf  = '0;
        if (be >= t_exp'(1)) begin
            base = {be[7:0], n[46:24]};
        end else begin
            shf  = t_exp'(1) - be;
            sh   = (shf > t_exp'(48)) ? 6'd48 : shf[5:0];
            m    = n >> sh;
            lost = |(n << (6'd48 - sh));
            base = {8'd0, m[46:24]};
        end
        inc = m[23] & ((|m[22:0]) | lost | m[24]);
        if (be >= t_exp'(255)) begin
            res = {sgn, 8'hFF, 23'd0};
        end else begin
            res = {sgn, base + 31'(inc)};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/frtd_coeff_table.sv @@
// Coefficient store: constant and linear terms in two memories, one per term.
// Depends on frtd_pkg for the table geometry.
`timescale 1ns / 1ps
`default_nettype none

module frtd_coeff_table (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [frtd_pkg::SLOT_W-1:0]      i_wr_slot,
    input  wire logic [frtd_pkg::WORD_W-1:0]      i_wr_word,
    input  wire logic [frtd_pkg::IDX_W-1:0]       i_rd_idx,
    output logic      [frtd_pkg::WORD_W-1:0]      o_const_word,
    output logic      [frtd_pkg::WORD_W-1:0]      o_linear_word
);

    logic [frtd_pkg::WORD_W-1:0] r_const_mem  [frtd_pkg::TABLE_DEPTH];
    logic [frtd_pkg::WORD_W-1:0] r_linear_mem [frtd_pkg::TABLE_DEPTH];

    // The low slot bit selects the term, the rest the interval.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (i_wr_slot[0]) begin
                r_linear_mem[i_wr_slot[frtd_pkg::IDX_W:1]] <= i_wr_word;
            end else begin
                r_const_mem[i_wr_slot[frtd_pkg::IDX_W:1]] <= i_wr_word;
            end
        end
    end

    // Registered read of both terms of one interval.
    always_ff @(posedge i_clk) begin
        o_const_word  <= r_const_mem[i_rd_idx];
        o_linear_word <= r_linear_mem[i_rd_idx];
    end

endmodule

`default_nettype wire

@@ rtl/core/frtd_recip_pipe.sv @@
// Reciprocal pipeline: coefficient decode, linear term, alignment, sum,
// conversion to float and scaling by the argument's exponent. Uses frtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frtd_recip_pipe (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic                              i_is_div,
    input  wire logic [frtd_pkg::FP_W-1:0]         i_divisor,
    input  wire logic [frtd_pkg::FP_W-1:0]         i_numerator,
    input  wire logic [frtd_pkg::WORD_W-1:0]       i_const_word,
    input  wire logic [frtd_pkg::WORD_W-1:0]       i_linear_word,
    input  wire logic [frtd_pkg::WIDTH_W-1:0]      i_const_width,
    input  wire logic [frtd_pkg::WIDTH_W-1:0]      i_linear_width,
    output frtd_pkg::t_recip_res                   o_res
);

    // Per-item data that rides alongside the arithmetic.
    typedef struct packed {
        logic                          valid;
        logic                          is_div;
        logic [frtd_pkg::FP_W-1:0]     num;
        logic                          sgn;
        logic [7:0]                    exp8;
        logic                          spec;
        logic [frtd_pkg::FP_W-1:0]     spec_val;
    } t_side;

    t_side n_a_side, r_a_side, r_b_side, r_c_side, r_d_side, r_e_side;

    // Stage A: decode argument and coefficients.
    logic [8:0]                       c_top0, c_top1;
    logic [frtd_pkg::XS-1:0]          c_xraw;
    logic [frtd_pkg::COEF_W-1:0]      n_a_m0, n_a_m1, r_a_m0, r_a_m1;
    logic [frtd_pkg::XL_W-1:0]        n_a_xl, r_a_xl;
    logic                             n_a_offneg, r_a_offneg;
    logic [7:0]                       r_a_be0, r_a_be1;
    logic                             r_a_neg0, r_a_neg1;

    always_comb begin
        c_top0 = 9'(i_const_word >> i_const_width);
        c_top1 = 9'(i_linear_word >> i_linear_width);
        n_a_m0 = frtd_pkg::COEF_W'(i_const_word & ((64'd1 << i_const_width) - 64'd1))
               | (frtd_pkg::COEF_W'(c_top0[7:0] != 8'd0) << i_const_width);
        n_a_m1 = frtd_pkg::COEF_W'(i_linear_word & ((64'd1 << i_linear_width) - 64'd1))
               | (frtd_pkg::COEF_W'(c_top1[7:0] != 8'd0) << i_linear_width);

        // Offset from the interval midpoint as sign and magnitude.
        c_xraw     = i_divisor[frtd_pkg::XS-1:0];
        n_a_offneg = !c_xraw[frtd_pkg::XS-1];
        if (n_a_offneg) begin
            n_a_xl = {1'b0, ~c_xraw[frtd_pkg::XS-2:0]} + frtd_pkg::XL_W'(1);
        end else begin
            n_a_xl = {1'b0, c_xraw[frtd_pkg::XS-2:0]};
        end

        // Infinite, NaN, zero and subnormal arguments bypass the arithmetic.
        n_a_side.valid    = i_valid;
        n_a_side.is_div   = i_is_div;
        n_a_side.num      = i_numerator;
        n_a_side.sgn      = i_divisor[31];
        n_a_side.exp8     = i_divisor[30:23];
        n_a_side.spec     = 1'b0;
        n_a_side.spec_val = '0;
        if (i_divisor[30:23] == 8'hFF) begin
            n_a_side.spec     = 1'b1;
            n_a_side.spec_val = (i_divisor[22:0] != 23'd0) ? frtd_pkg::CANON_NAN
                                                           : {i_divisor[31], 31'd0};
        end else if (i_divisor[30:23] == 8'd0) begin
            n_a_side.spec     = 1'b1;
            n_a_side.spec_val = {i_divisor[31], 8'hFF, 23'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
        end else begin
            r_a_side <= n_a_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_m0     <= n_a_m0;
        r_a_m1     <= n_a_m1;
        r_a_xl     <= n_a_xl;
        r_a_offneg <= n_a_offneg;
        r_a_be0    <= c_top0[7:0];
        r_a_be1    <= c_top1[7:0];
        r_a_neg0   <= c_top0[8];
        r_a_neg1   <= c_top1[8];
    end

    // Stage B: linear product and alignment shifts.
    frtd_pkg::t_exp                   c_diff;
    logic [6:0]                       n_b_sh0, n_b_sh1, r_b_sh0, r_b_sh1;
    logic [frtd_pkg::PROD_W-1:0]      r_b_prod;
    logic [frtd_pkg::COEF_W-1:0]      r_b_m0;
    logic                             r_b_neg0, r_b_lneg;

    always_comb begin
        c_diff  = frtd_pkg::t_exp'(r_a_be1) - frtd_pkg::t_exp'(r_a_be0)
                - frtd_pkg::t_exp'(frtd_pkg::XS - 1);
        n_b_sh0 = 7'd0;
        n_b_sh1 = 7'd0;
        if (c_diff > frtd_pkg::t_exp'(0)) begin
            n_b_sh0 = (c_diff >= frtd_pkg::t_exp'(64)) ? 7'd64 : 7'(c_diff);
        end else if (c_diff < frtd_pkg::t_exp'(0)) begin
            n_b_sh1 = (c_diff <= frtd_pkg::t_exp'(-64)) ? 7'd64 : 7'(-c_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_side <= '0;
        end else begin
            r_b_side <= r_a_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_prod <= frtd_pkg::PROD_W'(r_a_m1) * frtd_pkg::PROD_W'(r_a_xl);
        r_b_m0   <= r_a_m0;
        r_b_sh0  <= n_b_sh0;
        r_b_sh1  <= n_b_sh1;
        r_b_neg0 <= r_a_neg0;
        r_b_lneg <= r_a_neg1 != r_a_offneg;
    end

    // Stage C: aligned signed sum, modulo 2^64.
    logic [63:0] c_a0, c_a1, n_c_y, r_c_y;

    always_comb begin
        c_a0  = r_b_sh0[6] ? 64'd0 : (64'(r_b_m0) >> r_b_sh0[5:0]);
        c_a1  = r_b_sh1[6] ? 64'd0 : (64'(r_b_prod) >> r_b_sh1[5:0]);
        n_c_y = (r_b_neg0 ? (64'd0 - c_a0) : c_a0) + (r_b_lneg ? (64'd0 - c_a1) : c_a1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side <= '0;
        end else begin
            r_c_side <= r_b_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_y <= n_c_y;
    end

    // Stage D: leading zero count of the sum.
    logic [63:0] r_d_y;
    logic [6:0]  r_d_lz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side <= '0;
        end else begin
            r_d_side <= r_c_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_y  <= r_c_y;
        r_d_lz <= frtd_pkg::clz64(r_c_y);
    end

    // Stage E: normalise and round the sum to a 24-bit significand.
    logic [63:0] c_nrm;
    logic        c_inc;
    logic [24:0] c_q25;
    logic [23:0] n_e_q, r_e_q;
    logic [6:0]  n_e_p, r_e_p;
    logic        r_e_zero;

    always_comb begin
        c_nrm = r_d_y << r_d_lz;
        c_inc = c_nrm[39] & ((|c_nrm[38:0]) | c_nrm[40]);
        c_q25 = {1'b0, c_nrm[63:40]} + 25'(c_inc);
        if (c_q25[24]) begin
            n_e_q = c_q25[24:1];
            n_e_p = 7'd64 - r_d_lz;
        end else begin
            n_e_q = c_q25[23:0];
            n_e_p = 7'd63 - r_d_lz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_side <= '0;
        end else begin
            r_e_side <= r_d_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_q    <= n_e_q;
        r_e_p    <= n_e_p;
        r_e_zero <= r_d_y == 64'd0;
    end

    // Stage F: divide by 2^24, scale by 2^(bias - E) and round once more.
    frtd_pkg::t_exp             c_be;
    logic [frtd_pkg::FP_W-1:0]  c_recip;

    always_comb begin
        c_be = frtd_pkg::t_exp'(r_e_p) - frtd_pkg::t_exp'(frtd_pkg::Y_SCALE_LOG2)
             + frtd_pkg::t_exp'(2 * frtd_pkg::EXP_BIAS) - frtd_pkg::t_exp'(r_e_side.exp8);
        if (r_e_side.spec) begin
            c_recip = r_e_side.spec_val;
        end else if (r_e_zero) begin
            c_recip = {r_e_side.sgn, 31'd0};
        end else begin
            c_recip = frtd_pkg::round_pack(r_e_side.sgn, c_be, {r_e_q, 24'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res.valid <= 1'b0;
        end else begin
            o_res.valid <= r_e_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res.is_div <= r_e_side.is_div;
        o_res.num    <= r_e_side.num;
        o_res.recip  <= c_recip;
    end

endmodule

`default_nettype wire

@@ rtl/core/frtd_fmul_pipe.sv @@
// Four-stage fp32 multiplier with round to nearest even and subnormals;
// passes the reciprocal straight through for reciprocal requests. Uses frtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frtd_fmul_pipe (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  frtd_pkg::t_recip_res               i_req,
    output logic                               o_valid,
    output logic [frtd_pkg::FP_W-1:0]          o_result
);

    typedef struct packed {
        logic                          valid;
        logic                          sgn;
        logic                          spec;
        logic [frtd_pkg::FP_W-1:0]     spec_val;
    } t_side;

    t_side n_1_side, r_1_side, r_2_side, r_3_side;

    // Stage 1: unpack, special operands, significand product.
    logic [7:0]  c_ea, c_eb;
    logic [23:0] c_ma, c_mb;
    logic        c_nan_a, c_nan_b, c_inf_a, c_inf_b, c_zero_a, c_zero_b;
    logic [47:0] r_1_prod;
    logic [8:0]  r_1_esum;

    always_comb begin
        c_ea     = i_req.num[30:23];
        c_eb     = i_req.recip[30:23];
        c_ma     = {c_ea != 8'd0, i_req.num[22:0]};
        c_mb     = {c_eb != 8'd0, i_req.recip[22:0]};
        c_nan_a  = (c_ea == 8'hFF) && (i_req.num[22:0] != 23'd0);
        c_nan_b  = (c_eb == 8'hFF) && (i_req.recip[22:0] != 23'd0);
        c_inf_a  = (c_ea == 8'hFF) && (i_req.num[22:0] == 23'd0);
        c_inf_b  = (c_eb == 8'hFF) && (i_req.recip[22:0] == 23'd0);
        c_zero_a = (c_ea == 8'd0) && (i_req.num[22:0] == 23'd0);
        c_zero_b = (c_eb == 8'd0) && (i_req.recip[22:0] == 23'd0);

        n_1_side.valid    = i_req.valid;
        n_1_side.sgn      = i_req.num[31] ^ i_req.recip[31];
        n_1_side.spec     = 1'b1;
        n_1_side.spec_val = '0;
        if (!i_req.is_div) begin
            n_1_side.spec_val = i_req.recip;
        end else if (c_nan_a || c_nan_b || (c_inf_a && c_zero_b) || (c_zero_a && c_inf_b)) begin
            n_1_side.spec_val = frtd_pkg::CANON_NAN;
        end else if (c_inf_a || c_inf_b) begin
            n_1_side.spec_val = {n_1_side.sgn, 8'hFF, 23'd0};
        end else if (c_zero_a || c_zero_b) begin
            n_1_side.spec_val = {n_1_side.sgn, 31'd0};
        end else begin
            n_1_side.spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_side <= '0;
        end else begin
            r_1_side <= n_1_side;
        end
    end

    // A subnormal operand counts with exponent one and no hidden bit.
    always_ff @(posedge i_clk) begin
        r_1_prod <= 48'(c_ma) * 48'(c_mb);
        r_1_esum <= 9'((c_ea == 8'd0) ? 8'd1 : c_ea) + 9'((c_eb == 8'd0) ? 8'd1 : c_eb);
    end

    // Stage 2: leading zero count of the product.
    logic [47:0] r_2_prod;
    logic [8:0]  r_2_esum;
    logic [5:0]  r_2_lz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_2_side <= '0;
        end else begin
            r_2_side <= r_1_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_2_prod <= r_1_prod;
        r_2_esum <= r_1_esum;
        r_2_lz   <= frtd_pkg::clz48(r_1_prod);
    end

    // Stage 3: normalise and form the biased exponent.
    logic [47:0]    r_3_nrm;
    frtd_pkg::t_exp r_3_be;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_3_side <= '0;
        end else begin
            r_3_side <= r_2_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_3_nrm <= r_2_prod << r_2_lz;
        r_3_be  <= frtd_pkg::t_exp'(r_2_esum) - frtd_pkg::t_exp'(frtd_pkg::EXP_BIAS - 1)
                 - frtd_pkg::t_exp'(r_2_lz);
    end

    // Stage 4: round, pack and drive the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_3_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_3_side.spec) begin
            o_result <= r_3_side.spec_val;
        end else begin
            o_result <= frtd_pkg::round_pack(r_3_side.sgn, r_3_be, r_3_nrm);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fp32_table_reciprocal_divider.sv @@
// A request's result comes through the request register, the reciprocal pipeline and the
// multiplier pipeline; table writes and unused codes give no result.
// Throughput: one request per cycle; busy is never raised, as the pipeline
// cannot stall. Width registers take a write whenever cfg valid is high, ready always high.
// Reset clears the pipeline valid bits and sets both widths to 23; the
// coefficient table keeps its contents and is undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module fp32_table_reciprocal_divider (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [1:0]                           i_op,
    input  wire logic [frtd_pkg::SLOT_W-1:0]          i_table_slot,
    input  wire logic [frtd_pkg::WORD_W-1:0]          i_table_word,
    input  wire logic [frtd_pkg::FP_W-1:0]            i_divisor_bits,
    input  wire logic [frtd_pkg::FP_W-1:0]            i_numerator_bits,
    output logic                                      o_result_valid,
    output logic      [frtd_pkg::FP_W-1:0]            o_result_bits,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [frtd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [frtd_pkg::WIDTH_W-1:0]         i_cfg_data
);

    logic                              c_accept;
    logic                              c_table_wr;
    logic [frtd_pkg::IDX_W-1:0]        c_idx;
    logic [frtd_pkg::WIDTH_W-1:0]      c_cfg_width;
    logic [frtd_pkg::WIDTH_W-1:0]      r_const_width, r_linear_width;
    logic                              r_s1_valid, r_s1_div;
    logic [frtd_pkg::FP_W-1:0]         r_s1_divisor, r_s1_numerator;
    logic [frtd_pkg::WORD_W-1:0]       c_const_word, c_linear_word;
    frtd_pkg::t_recip_res              c_recip;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign c_accept    = start && !busy;

    // Width registers, clamped to their legal range on write.
    always_comb begin
        if (i_cfg_data < frtd_pkg::WIDTH_W'(frtd_pkg::WIDTH_MIN)) begin
            c_cfg_width = frtd_pkg::WIDTH_W'(frtd_pkg::WIDTH_MIN);
        end else if (i_cfg_data > frtd_pkg::WIDTH_W'(frtd_pkg::WIDTH_MAX)) begin
            c_cfg_width = frtd_pkg::WIDTH_W'(frtd_pkg::WIDTH_MAX);
        end else begin
            c_cfg_width = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const_width  <= frtd_pkg::WIDTH_W'(frtd_pkg::WIDTH_RST);
            r_linear_width <= frtd_pkg::WIDTH_W'(frtd_pkg::WIDTH_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == frtd_pkg::CFG_CONST_WIDTH) begin
                r_const_width <= c_cfg_width;
            end else if (i_cfg_index == frtd_pkg::CFG_LINEAR_WIDTH) begin
                r_linear_width <= c_cfg_width;
            end
        end
    end

    // Table write and the interval index of the incoming argument.
    always_comb begin
        c_table_wr = c_accept && (i_op == frtd_pkg::OP_WRITE)
                  && ({1'b0, i_table_slot} < (frtd_pkg::SLOT_W + 1)'(2 * frtd_pkg::TABLE_DEPTH));
        c_idx = i_divisor_bits[frtd_pkg::FRAC_BITS-1:frtd_pkg::XS];
        if ({1'b0, c_idx} >= (frtd_pkg::IDX_W + 1)'(frtd_pkg::TABLE_DEPTH)) begin
            c_idx = frtd_pkg::IDX_W'(frtd_pkg::TABLE_DEPTH - 1);
        end
    end

    frtd_coeff_table u_table (
        .i_clk         (i_clk),
        .i_wr_en       (c_table_wr),
        .i_wr_slot     (i_table_slot),
        .i_wr_word     (i_table_word),
        .i_rd_idx      (c_idx),
        .o_const_word  (c_const_word),
        .o_linear_word (c_linear_word)
    );

    // Request register, aligned with the table read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= c_accept
                       && ((i_op == frtd_pkg::OP_RECIP) || (i_op == frtd_pkg::OP_DIVIDE));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_div       <= i_op == frtd_pkg::OP_DIVIDE;
        r_s1_divisor   <= i_divisor_bits;
        r_s1_numerator <= i_numerator_bits;
    end

    frtd_recip_pipe u_recip (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_s1_valid),
        .i_is_div       (r_s1_div),
        .i_divisor      (r_s1_divisor),
        .i_numerator    (r_s1_numerator),
        .i_const_word   (c_const_word),
        .i_linear_word  (c_linear_word),
        .i_const_width  (r_const_width),
        .i_linear_width (r_linear_width),
        .o_res          (c_recip)
    );

    frtd_fmul_pipe u_fmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (c_recip),
        .o_valid  (o_result_valid),
        .o_result (o_result_bits)
    );

endmodule

`default_nettype wire

@@ rtl/core/frtd_checker.sv @@
// Port-level checks on result timing and special-case results, bound to the
// top level. Depends on frtd_pkg and fp32_table_reciprocal_divider.
`timescale 1ns / 1ps
`default_nettype none

module frtd_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    input  wire logic                                 busy,
    input  wire logic [1:0]                           i_op,
    input  wire logic [frtd_pkg::SLOT_W-1:0]          i_table_slot,
    input  wire logic [frtd_pkg::WORD_W-1:0]          i_table_word,
    input  wire logic [frtd_pkg::FP_W-1:0]            i_divisor_bits,
    input  wire logic [frtd_pkg::FP_W-1:0]            i_numerator_bits,
    input  wire logic                                 o_result_valid,
    input  wire logic [frtd_pkg::FP_W-1:0]            o_result_bits,
    input  wire logic                                 i_cfg_valid,
    input  wire logic                                 o_cfg_ready,
    input  wire logic [frtd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [frtd_pkg::WIDTH_W-1:0]         i_cfg_data
);

    logic c_req;
    assign c_req = start && !busy
                && ((i_op == frtd_pkg::OP_RECIP) || (i_op == frtd_pkg::OP_DIVIDE));

    // Every result strobe belongs to a reciprocal or divide request.
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(c_req, frtd_pkg::PIPE_LATENCY))
        else $error("result strobe without a matching request");

    // A NaN divisor always yields the canonical NaN.
    a_nan_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(c_req && (i_divisor_bits[30:23] == 8'hFF)
                                 && (i_divisor_bits[22:0] != 23'd0), frtd_pkg::PIPE_LATENCY))
        |-> (o_result_bits == frtd_pkg::CANON_NAN))
        else $error("NaN divisor did not give canonical NaN");

    // The reciprocal of infinity is zero with the argument's sign.
    a_inf_recip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(start && !busy && (i_op == frtd_pkg::OP_RECIP)
                                 && (i_divisor_bits[30:0] == 31'h7F80_0000),
                                 frtd_pkg::PIPE_LATENCY))
        |-> (o_result_bits == {$past(i_divisor_bits[31], frtd_pkg::PIPE_LATENCY), 31'd0}))
        else $error("reciprocal of infinity is not a signed zero");

    // The reciprocal of zero or a subnormal is infinity with the argument's sign.
    a_zero_recip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(start && !busy && (i_op == frtd_pkg::OP_RECIP)
                                 && (i_divisor_bits[30:23] == 8'd0), frtd_pkg::PIPE_LATENCY))
        |-> (o_result_bits == {$past(i_divisor_bits[31], frtd_pkg::PIPE_LATENCY),
                               8'hFF, 23'd0}))
        else $error("reciprocal of zero or subnormal is not a signed infinity");

endmodule

bind fp32_table_reciprocal_divider frtd_checker u_frtd_checker (.*);

`default_nettype wire
